// ===== hw/rtl/positional_list_engine_unit_macros.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define PLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ple_pkg.sv =====
package ple_pkg;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned KIND_W     = 2;
  // Wide enough for an entry count of the largest supported depth (4096).
  localparam int unsigned LIST_CNT_W = 13;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET    = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_FIND   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } ple_cmd_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         entry_count;
    logic                     empty_res;
  } ple_res_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                     insert;
    logic                     remove;
    logic                     scan_get;
    logic                     scan_find;
    logic [POS_W-1:0]         position;
    logic [LIST_CNT_W-1:0]    count;
    logic signed [DATA_W-1:0] value;
  } ple_ctrl_t;

  // Search token that walks down the chain, one cell per cycle.
  typedef struct packed {
    logic                     valid;
    logic                     hit;
    logic [POS_W-1:0]         slot;
    logic signed [DATA_W-1:0] data;
  } ple_carry_t;

endpackage

// ===== hw/rtl/positional_list_engine_unit.sv =====
// Ordered list of up to DEPTH signed 32-bit words, edited by 1-based position.
// A command word is taken on cmd_i at a rising edge where start is high and
// busy is low. Each command yields exactly one result word on res_o, shown for
// a single cycle while done_o is high; the receiver cannot stall, so it must
// take the word in that cycle.
// Insert, delete and a get whose position is out of range need no search:
// the result appears in the cycle after acceptance and busy stays low,
// so these commands may be issued every cycle.
// An in-range get and a find send a search token down the row of cells, one
// cell per clock, through launch_q and the carry register of every cell; busy
// stays high until the token leaves the last cell and done_o rises.
// Insert and delete shift every stored word at or behind the position by one cell in parallel.
// Reset clears the entry count and any search in flight; the stored words
// themselves are not cleared, and only words below the count are ever read.
// Failed commands (bad position, insert into a full list) report ok low and
// leave the list unchanged.
module positional_list_engine_unit import ple_pkg::*; #(
  parameter int unsigned DEPTH = LIST_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ple_cmd_t cmd_i,
  output logic     done_o,
  output ple_res_t res_o
);
  `include "positional_list_engine_unit_macros.svh"

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     done_q, done_d;
  ple_res_t                 res_q, res_d;
  logic                     launch_q, launch_d;
  kind_e                    kind_q, kind_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic [POS_W-1:0]         pos_q, pos_d;

  logic                     accept;
  logic [LIST_CNT_W-1:0]    pos_x;
  logic [LIST_CNT_W-1:0]    cnt_x;
  logic                     pos_nz;
  logic                     in_range;
  logic                     ins_ok;
  logic [CNT_W-1:0]         cnt_new;

  ple_ctrl_t                ctrl;
  ple_carry_t               carry [DEPTH+1];
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         token_vec;

  assign accept   = start && !busy;
  assign pos_x    = LIST_CNT_W'(cmd_i.position);
  assign cnt_x    = LIST_CNT_W'(count_q);
  assign pos_nz   = (cmd_i.position != '0);
  // Valid for get and delete: a position from one to the count.
  assign in_range = pos_nz && (pos_x <= cnt_x);
  // Insert may also append at count + 1, but never into a full list.
  assign ins_ok   = pos_nz && (pos_x <= (cnt_x + LIST_CNT_W'(1))) &&
                    (count_q != CNT_W'(DEPTH));

  // Commands that edit the list act on all cells in the accept cycle; a
  // search uses the registered key and position while the token walks.
  always_comb begin
    ctrl           = '0;
    ctrl.insert    = accept && (cmd_i.kind == KIND_INSERT) && ins_ok;
    ctrl.remove    = accept && (cmd_i.kind == KIND_DELETE) && in_range;
    ctrl.scan_get  = (kind_q == KIND_GET);
    ctrl.scan_find = (kind_q == KIND_FIND);
    ctrl.position  = busy ? pos_q : cmd_i.position;
    ctrl.value     = busy ? key_q : cmd_i.value;
    ctrl.count     = cnt_x;
  end

  assign carry[0] = ple_carry_t'{valid: launch_q, hit: 1'b0, slot: '0, data: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = cell_data[0];
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_data[DEPTH-1];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    ple_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .carry_i (carry[i]),
      .carry_o (carry[i+1])
    );

    assign token_vec[i] = carry[i+1].valid;
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    done_d   = 1'b0;
    res_d    = res_q;
    launch_d = 1'b0;
    kind_d   = kind_q;
    key_d    = key_q;
    pos_d    = pos_q;
    cnt_new  = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d = cmd_i.kind;
          key_d  = cmd_i.value;
          pos_d  = cmd_i.position;
          res_d  = '0;
          unique case (cmd_i.kind)
            KIND_GET: begin
              if (in_range) begin
                launch_d = 1'b1;
                state_d  = ST_SCAN;
              end else begin
                done_d = 1'b1;
              end
            end
            KIND_INSERT: begin
              done_d = 1'b1;
              if (ins_ok) begin
                cnt_new = count_q + CNT_W'(1);
              end
              res_d.ok = ins_ok;
            end
            KIND_DELETE: begin
              done_d = 1'b1;
              if (in_range) begin
                cnt_new = count_q - CNT_W'(1);
              end
              res_d.ok = in_range;
            end
            KIND_FIND: begin
              launch_d = 1'b1;
              state_d  = ST_SCAN;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
          count_d           = cnt_new;
          res_d.entry_count = POS_W'(cnt_new);
          res_d.empty_res   = (cnt_new == '0);
        end
      end
      ST_SCAN: begin
        if (carry[DEPTH].valid) begin
          done_d               = 1'b1;
          state_d              = ST_IDLE;
          res_d.ok             = carry[DEPTH].hit;
          res_d.read_value     = (kind_q == KIND_GET) ? carry[DEPTH].data : '0;
          res_d.found_position = (kind_q == KIND_FIND && carry[DEPTH].hit) ?
                                 carry[DEPTH].slot : '0;
          res_d.entry_count    = POS_W'(count_q);
          res_d.empty_res      = (count_q == '0);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      launch_q <= 1'b0;
      res_q    <= '0;
      kind_q   <= KIND_GET;
      key_q    <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      launch_q <= launch_d;
      res_q    <= res_d;
      kind_q   <= kind_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
    end
  end

  assign busy   = (state_q == ST_SCAN);
  assign done_o = done_q;
  assign res_o  = res_q;

  // The count never passes the number of cells.
  `PLE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "entry count above depth")
  // Only one search token is ever in the chain.
  `PLE_ASSERT(a_one_token, clk_i, rst_ni, $onehot0(token_vec), "more than one search token")
  // A result is never reported while a search is still running.
  `PLE_ASSERT(a_no_done_busy, clk_i, rst_ni, !(done_o && busy), "result during search")
  // Every search that ends reports its result.
  `PLE_ASSERT(a_scan_reports, clk_i, rst_ni, !$fell(busy) || done_o, "search ended silently")
  // A launched token enters the chain while the engine is busy.
  `PLE_ASSERT_NEXT(a_launch_busy, clk_i, rst_ni, launch_q, busy, "token left search early")

endmodule

// ===== hw/rtl/ple_cell.sv =====
module ple_cell import ple_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ple_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  output logic signed [DATA_W-1:0] data_o,
  input  ple_carry_t               carry_i,
  output ple_carry_t               carry_o
);

  // One-based list position held by this cell.
  localparam logic [LIST_CNT_W-1:0] SLOT = LIST_CNT_W'(IDX + 1);

  logic signed [DATA_W-1:0] data_q, data_d;
  ple_carry_t               carry_q, carry_d;
  logic [LIST_CNT_W-1:0]    pos_x;
  logic                     match;

  assign pos_x = LIST_CNT_W'(ctrl_i.position);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.insert) begin
      if (SLOT == pos_x) begin
        data_d = ctrl_i.value;
      end else if (SLOT > pos_x) begin
        data_d = left_i;
      end
    end else if (ctrl_i.remove && (SLOT >= pos_x)) begin
      data_d = right_i;
    end
  end

  assign match = (ctrl_i.scan_get && (SLOT == pos_x)) ||
                 (ctrl_i.scan_find && (data_q == ctrl_i.value) && (SLOT <= ctrl_i.count));

  always_comb begin
    carry_d = carry_i;
    if (carry_i.valid && !carry_i.hit && match) begin
      carry_d.hit  = 1'b1;
      carry_d.slot = POS_W'(IDX + 1);
      carry_d.data = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign data_o  = data_q;
  assign carry_o = carry_q;

endmodule
